// ===== rtl/core/pds_pkg.sv =====
// Shared widths, constants and register indexes for the PLL divider search.
`timescale 1ns / 1ps

package pds_pkg;

    // Fixed field widths of the request, the result and the registers
    localparam int REF_FREQ_W  = 16;
    localparam int CLK_W       = 17;
    localparam int POST_W      = 4;
    localparam int DIV_FIELD_W = 8;

    // Default for the divider register width
    localparam int DIVIDER_BITS_DEF = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int NUM_W  = DIV_FIELD_W + REF_FREQ_W + 1;   // 2*fb*ref_clk
    localparam int DEN_W  = DIV_FIELD_W + POST_W;           // ref*post
    localparam int K_W    = NUM_W + 1;                      // best_num + step*best_den
    localparam int D_W    = CLK_W + DEN_W;                  // desired*den
    localparam int STEP_W = REF_FREQ_W + 1;                 // 2*ref_clk

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = K_W;
    localparam int MUL_B_W = DEN_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Minimum improvement of the best clock, 1.5 MHz in 10 kHz units
    localparam int MIN_STEP = 150;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_FREQ    = 3'd0,
        CFG_MIN_REF_DIV = 3'd1,
        CFG_MAX_REF_DIV = 3'd2,
        CFG_MIN_FB_DIV  = 3'd3,
        CFG_MAX_FB_DIV  = 3'd4
    } cfg_idx_t;

endpackage

// ===== rtl/core/pll_divider_search_unit.sv =====
// Top level of the PLL divider search: registers, sequencer and result.
`timescale 1ns / 1ps

// PLL divider search. A request (target clock, ceiling clock, post divider) is
// taken when start is high and busy is low; busy then stays high until the
// result has been shown. The result is on found/ref_divider/fb_divider/
// achieved_clock, marked by done for exactly one cycle, and must be captured
// in that cycle: the block never waits for the receiver. A request visits
// reference dividers from the largest configured value down to the smallest
// and, for each one that passes the ceiling test, feedback dividers from the
// smallest configured value upward. All products go through a single
// registered multiplier, so a reference divider is set up in S_RSTART,
// S_CEIL, S_DES and S_FSTART, and each visited feedback divider passes
// through S_LHS, S_RHS and S_CMP; the row ends early once the candidate
// exceeds the target clock. The final clock comes from a bit-serial divide
// of the best candidate. A post divider of zero skips the search and
// answers "not found".
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while busy is low.

module pll_divider_search_unit
    import pds_pkg::*;
#(
    parameter int DIVIDER_BITS = DIVIDER_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Request transaction
    input  logic                   start,
    output logic                   busy,
    input  logic [CLK_W-1:0]       target_clock,
    input  logic [CLK_W-1:0]       ceiling_clock,
    input  logic [POST_W-1:0]      post_scale,

    // Result transaction, one cycle wide
    output logic                   done,
    output logic                   found,
    output logic [DIV_FIELD_W-1:0] ref_divider,
    output logic [DIV_FIELD_W-1:0] fb_divider,
    output logic [CLK_W-1:0]       achieved_clock,

    // Configuration write transaction
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Divider registers keep only the low DIVIDER_BITS bits of the 8-bit field, at most all 8
    localparam int DIV_W = (DIVIDER_BITS < DIV_FIELD_W) ? DIVIDER_BITS : DIV_FIELD_W;

    // Sequencer states, one-hot
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_TOP    = 14'b00000000000010,  // issue ref clock * max_fb
        S_NUM0   = 14'b00000000000100,  // issue ref clock * min_fb, take ceiling limit
        S_INIT   = 14'b00000000001000,  // take first numerator
        S_RSTART = 14'b00000000010000,  // test ref range, issue ref * post
        S_CEIL   = 14'b00000000100000,  // take den, issue ceiling * den
        S_DES    = 14'b00000001000000,  // ceiling test, issue desired * den
        S_FSTART = 14'b00000010000000,  // take desired limit, start feedback sweep
        S_LHS    = 14'b00000100000000,  // desired test, issue num * best_den
        S_RHS    = 14'b00001000000000,  // take lhs, issue k * den
        S_CMP    = 14'b00010000000000,  // step test, accept, advance
        S_FIN    = 14'b00100000000000,  // launch divide if anything was found
        S_DIVW   = 14'b01000000000000,  // wait for the divider
        S_DONE   = 14'b10000000000000   // show the result
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [REF_FREQ_W-1:0] pll_ref_reg;
    logic [DIV_W-1:0]      min_ref_reg;
    logic [DIV_W-1:0]      max_ref_reg;
    logic [DIV_W-1:0]      min_fb_reg;
    logic [DIV_W-1:0]      max_fb_reg;

    // Request registers
    logic [CLK_W-1:0]  desired_reg,  desired_next;
    logic [CLK_W-1:0]  ceiling_reg,  ceiling_next;
    logic [POST_W-1:0] post_reg,     post_next;

    // Search registers
    logic [NUM_W-1:0]  top_reg,      top_next;
    logic [NUM_W-1:0]  num0_reg,     num0_next;
    logic [DIV_W-1:0]  r_reg,        r_next;
    logic [DIV_W-1:0]  f_reg,        f_next;
    logic [DEN_W-1:0]  den_reg,      den_next;
    logic [D_W-1:0]    dlim_reg,     dlim_next;
    logic [NUM_W-1:0]  num_reg,      num_next;
    logic [PROD_W-1:0] lhs_reg,      lhs_next;

    // Best candidate so far
    logic              found_reg,    found_next;
    logic [NUM_W-1:0]  best_num_reg, best_num_next;
    logic [DEN_W-1:0]  best_den_reg, best_den_next;
    logic [K_W-1:0]    k_reg,        k_next;
    logic [DIV_W-1:0]  best_ref_reg, best_ref_next;
    logic [DIV_W-1:0]  best_fb_reg,  best_fb_next;

    // Shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;

    // Final divide
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   quotient;

    logic [STEP_W-1:0]  num_step;

    pds_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (best_num_reg),
        .divisor  (best_den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // The numerator grows by twice the reference clock for each feedback divider step
    assign num_step = {pll_ref_reg, 1'b0};

    // Multiplier operand select: each state issues the product the next state needs
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TOP:
            begin
                mul_a = MUL_A_W'(pll_ref_reg);
                mul_b = MUL_B_W'(max_fb_reg);
            end
            S_NUM0:
            begin
                mul_a = MUL_A_W'(pll_ref_reg);
                mul_b = MUL_B_W'(min_fb_reg);
            end
            S_RSTART:
            begin
                mul_a = MUL_A_W'(r_reg);
                mul_b = MUL_B_W'(post_reg);
            end
            S_CEIL:
            begin
                mul_a = MUL_A_W'(ceiling_reg);
                mul_b = prod[DEN_W-1:0];
            end
            S_DES:
            begin
                mul_a = MUL_A_W'(desired_reg);
                mul_b = den_reg;
            end
            S_LHS:
            begin
                mul_a = MUL_A_W'(num_reg);
                mul_b = best_den_reg;
            end
            S_RHS:
            begin
                mul_a = MUL_A_W'(k_reg);
                mul_b = den_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        desired_next  = desired_reg;
        ceiling_next  = ceiling_reg;
        post_next     = post_reg;
        top_next      = top_reg;
        num0_next     = num0_reg;
        r_next        = r_reg;
        f_next        = f_reg;
        den_next      = den_reg;
        dlim_next     = dlim_reg;
        num_next      = num_reg;
        lhs_next      = lhs_reg;
        found_next    = found_reg;
        best_num_next = best_num_reg;
        best_den_next = best_den_reg;
        k_next        = k_reg;
        best_ref_next = best_ref_reg;
        best_fb_next  = best_fb_reg;
        div_start     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    desired_next  = target_clock;
                    ceiling_next  = ceiling_clock;
                    post_next     = post_scale;
                    r_next        = max_ref_reg;
                    // Before any hit the best clock is 0/1
                    found_next    = 1'b0;
                    best_num_next = '0;
                    best_den_next = DEN_W'(1);
                    k_next        = K_W'(MIN_STEP);
                    best_ref_next = '0;
                    best_fb_next  = '0;
                    // A zero post divider has no candidates at all
                    state_next    = (post_scale == '0) ? S_FIN : S_TOP;
                end
            end

            S_TOP:
            begin
                state_next = S_NUM0;
            end

            S_NUM0:
            begin
                top_next   = {prod[NUM_W-2:0], 1'b0};
                state_next = S_INIT;
            end

            S_INIT:
            begin
                num0_next  = {prod[NUM_W-2:0], 1'b0};
                state_next = S_RSTART;
            end

            S_RSTART:
            begin
                // Stop below the smallest reference divider, and never visit zero
                if (r_reg == '0 || r_reg < min_ref_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CEIL;
                end
            end

            S_CEIL:
            begin
                den_next   = prod[DEN_W-1:0];
                state_next = S_DES;
            end

            S_DES:
            begin
                // Skip this reference divider when the ceiling is out of range
                if (prod >= PROD_W'(top_reg))
                begin
                    r_next     = r_reg - 1'b1;
                    state_next = S_RSTART;
                end
                else
                begin
                    state_next = S_FSTART;
                end
            end

            S_FSTART:
            begin
                dlim_next = prod[D_W-1:0];
                f_next    = min_fb_reg;
                num_next  = num0_reg;
                if (min_fb_reg > max_fb_reg)
                begin
                    r_next     = r_reg - 1'b1;
                    state_next = S_RSTART;
                end
                else
                begin
                    state_next = S_LHS;
                end
            end

            S_LHS:
            begin
                // The numerator only grows with fb: once above the desired
                // clock, drop the rest of this row
                if (D_W'(num_reg) > dlim_reg)
                begin
                    r_next     = r_reg - 1'b1;
                    state_next = S_RSTART;
                end
                else
                begin
                    state_next = S_RHS;
                end
            end

            S_RHS:
            begin
                lhs_next   = prod;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                // num/den >= best_num/best_den + step, cross-multiplied
                if (lhs_reg >= prod)
                begin
                    found_next    = 1'b1;
                    best_num_next = num_reg;
                    best_den_next = den_reg;
                    k_next        = K_W'(num_reg) + K_W'(den_reg) * K_W'(MIN_STEP);
                    best_ref_next = r_reg;
                    best_fb_next  = f_reg;
                end
                if (f_reg == max_fb_reg)
                begin
                    r_next     = r_reg - 1'b1;
                    state_next = S_RSTART;
                end
                else
                begin
                    f_next     = f_reg + 1'b1;
                    num_next   = num_reg + NUM_W'(num_step);
                    state_next = S_LHS;
                end
            end

            S_FIN:
            begin
                if (found_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            found_reg   <= 1'b0;
            pll_ref_reg <= REF_FREQ_W'(2700);
            min_ref_reg <= DIV_W'(4);
            max_ref_reg <= DIV_W'(150);
            min_fb_reg  <= DIV_W'(2);
            max_fb_reg  <= DIV_W'(150);
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_REF_FREQ:    pll_ref_reg <= cfg_data[REF_FREQ_W-1:0];
                    CFG_MIN_REF_DIV: min_ref_reg <= cfg_data[DIV_W-1:0];
                    CFG_MAX_REF_DIV: max_ref_reg <= cfg_data[DIV_W-1:0];
                    CFG_MIN_FB_DIV:  min_fb_reg  <= cfg_data[DIV_W-1:0];
                    CFG_MAX_FB_DIV:  max_fb_reg  <= cfg_data[DIV_W-1:0];
                    default:
                    begin
                        // Unknown index: drop the write
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        desired_reg  <= desired_next;
        ceiling_reg  <= ceiling_next;
        post_reg     <= post_next;
        top_reg      <= top_next;
        num0_reg     <= num0_next;
        r_reg        <= r_next;
        f_reg        <= f_next;
        den_reg      <= den_next;
        dlim_reg     <= dlim_next;
        num_reg      <= num_next;
        lhs_reg      <= lhs_next;
        best_num_reg <= best_num_next;
        best_den_reg <= best_den_next;
        k_reg        <= k_next;
        best_ref_reg <= best_ref_next;
        best_fb_reg  <= best_fb_next;
    end

    // Outputs: result fields are held in the best-candidate registers and the
    // divider quotient, so done alone marks the transaction
    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign cfg_ready      = 1'b1;
    assign found          = found_reg;
    assign ref_divider    = DIV_FIELD_W'(best_ref_reg);
    assign fb_divider     = DIV_FIELD_W'(best_fb_reg);
    assign achieved_clock = found_reg ? quotient[CLK_W-1:0] : '0;

    // A request is taken only when idle and always makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // After the result cycle the block goes back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    // A not-found result carries zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |->
            (ref_divider == '0 && fb_divider == '0 && achieved_clock == '0))
        else $error("not-found result with nonzero fields");

    // An accepted candidate never has a zero reference divider
    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_ref_reg != '0))
        else $error("accepted candidate with zero reference divider");

    // The divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVW))
        else $error("divider finished outside its wait state");

endmodule

// ===== rtl/core/pds_mul.sv =====
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module pds_mul
    import pds_pkg::*;
(
    input  logic               clk,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [PROD_W-1:0]  prod
);

    logic [PROD_W-1:0] prod_reg;

    // Register every product; the sequencer picks it up in the next cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/pds_div.sv =====
// Bit-serial restoring divider for the final clock truncation.
`timescale 1ns / 1ps

module pds_div
    import pds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] dvs_reg;
    logic [NUM_W-1:0] quo_reg;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_sub;
    logic             take;

    // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        take      = (rem_shift >= {1'b0, dvs_reg});
        rem_sub   = rem_shift - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], take};
            rem_reg <= take ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
